// File: src/swmi_pkg.sv
`default_nettype none
package swmi_pkg;

  localparam int unsigned MemWords   = 1024;
  localparam int unsigned MemAw      = $clog2(MemWords);
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned QueueAw    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);
  localparam int unsigned MaxOutputs = 63;
  localparam int unsigned OutCw      = 6;
  localparam logic [31:0] StepLimitReset = 32'd1000000;

  // item modes
  localparam logic [1:0] ModeLoad = 2'd0;
  localparam logic [1:0] ModePush = 2'd1;
  localparam logic [1:0] ModeRun  = 2'd2;
  localparam logic [1:0] ModeRead = 2'd3;

  // result kinds
  localparam logic [1:0] KindOut    = 2'd0;
  localparam logic [1:0] KindStatus = 2'd1;
  localparam logic [1:0] KindRead   = 2'd2;

  // run end status codes
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StBadMode = 3'd1;
  localparam logic [2:0] StImmWr   = 3'd2;
  localparam logic [2:0] StAddr    = 3'd3;
  localparam logic [2:0] StEmpty   = 3'd4;
  localparam logic [2:0] StSteps   = 3'd5;
  localparam logic [2:0] StOutCap  = 3'd6;

  // opcodes
  localparam logic [6:0] OpAdd  = 7'd1;
  localparam logic [6:0] OpMul  = 7'd2;
  localparam logic [6:0] OpIn   = 7'd3;
  localparam logic [6:0] OpOut  = 7'd4;
  localparam logic [6:0] OpJt   = 7'd5;
  localparam logic [6:0] OpJf   = 7'd6;
  localparam logic [6:0] OpLt   = 7'd7;
  localparam logic [6:0] OpEq   = 7'd8;
  localparam logic [6:0] OpHalt = 7'd99;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         address;
    logic signed [63:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [63:0] out_value;
    logic [2:0]         status;
    logic               last;
  } result_t;

  // one memory access request
  typedef struct packed {
    logic             we;
    logic [MemAw-1:0] addr;
    logic [63:0]      wdata;
  } mem_req_t;

endpackage
`default_nettype wire

// File: src/swmi_mem.sv
`default_nettype none
module swmi_mem (
  input  wire logic              clk_i,
  input  wire swmi_pkg::mem_req_t req_i,
  output logic [63:0]            rdata_o
);

  logic [63:0] mem_q [swmi_pkg::MemWords];

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.addr];
  end

endmodule
`default_nettype wire

// File: src/swmi_queue.sv
`default_nettype none
module swmi_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic [63:0] push_data_i,
  input  wire logic        pop_i,
  output logic             empty_o,
  output logic [63:0]      head_o
);

  logic [63:0]                   q_q [swmi_pkg::QueueDepth];
  logic [swmi_pkg::QueueAw-1:0]  head_q, head_d, tail;
  logic [swmi_pkg::QueueCw-1:0]  count_q, count_d;
  logic                          full, do_push;

  assign empty_o = (count_q == '0);
  assign full    = (count_q == swmi_pkg::QueueCw'(swmi_pkg::QueueDepth));
  assign do_push = push_i && !full;
  assign head_o  = q_q[head_q];

  // wrap tail around the ring
  always_comb begin
    logic [swmi_pkg::QueueCw:0] t;
    t = (swmi_pkg::QueueCw+1)'(head_q) + (swmi_pkg::QueueCw+1)'(count_q);
    if (t >= (swmi_pkg::QueueCw+1)'(swmi_pkg::QueueDepth)) begin
      t = t - (swmi_pkg::QueueCw+1)'(swmi_pkg::QueueDepth);
    end
    tail = t[swmi_pkg::QueueAw-1:0];
  end

  // advance head and count
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (pop_i && !empty_o) begin
      head_d = (32'(head_q) == swmi_pkg::QueueDepth - 1) ? '0 : head_q + 1'b1;
      count_d = count_d - 1'b1;
    end
    if (do_push) begin
      count_d = count_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_q[tail] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// File: src/small_word_machine_interpreter.sv
`default_nettype none
// Word machine interpreter. Load and push words are taken one per cycle while busy
// is low. A read word keeps busy high for one cycle and its data shows in the
// cycle after. A run executes the stored program from address zero on a
// single-port program memory with registered reads. Each step fetches the
// instruction word, then each argument word, then reads each position-mode
// operand that it uses from memory and takes each immediate one as it stands,
// hands over to execution and does the write, output or jump. A multiply first
// sums its 32-bit partial products. Halt and unknown opcodes fetch no arguments,
// and faults end the run early. busy stays high until the run has ended, and the
// status word shows in the cycle after its last busy cycle. The receiver cannot
// stall: each result shows for exactly one cycle with result_valid_o.
module small_word_machine_interpreter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire swmi_pkg::item_t   item_i,
  input  wire logic              cfg_we_i,
  input  wire logic [31:0]       cfg_wdata_i,
  output logic                   result_valid_o,
  output swmi_pkg::result_t      result_o
);

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StMul   = 10'b0000000010,
    StRdOut = 10'b0000000100,
    StChk   = 10'b0000001000,
    StFetch = 10'b0000010000,
    StDec   = 10'b0000100000,
    StArg   = 10'b0001000000,
    StOpnd  = 10'b0010000000,
    StExec  = 10'b0100000000,
    StEnd   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] step_limit_q;
  logic [31:0] steps_q, steps_d;
  logic [swmi_pkg::OutCw-1:0] outs_q, outs_d;
  logic [swmi_pkg::MemAw:0]   pc_q, pc_d;
  logic [6:0]  op_q, op_d;
  logic [3:0]  md0_q, md0_d, md1_q, md1_d, md2_q, md2_d;
  logic [1:0]  nargs_q, nargs_d, ai_q, ai_d;
  logic [63:0] a_q [3];
  logic [63:0] a_d [3];
  logic [63:0] x_q, x_d, y_q, y_d;
  logic [1:0]  oi_q, oi_d;        // operand index being resolved
  logic        wait_q, wait_d;    // memory read in flight
  logic [2:0]  st_q, st_d;
  logic [1:0]  mc_q, mc_d;        // partial product index
  logic [63:0] prod_q, prod_d;

  swmi_pkg::mem_req_t mreq;
  logic [63:0]        mrdata;
  logic               q_pop, q_empty;
  logic [63:0]        q_head;
  logic               item_acc;
  logic               rv_d;
  swmi_pkg::result_t  res_d;

  assign item_acc = start && !busy;
  assign busy     = (state_q != StIdle);

  swmi_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (mrdata)
  );

  swmi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (item_acc && item_i.mode == swmi_pkg::ModePush),
    .push_data_i (item_i.value),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // decimal digit split of a 17-bit word
  logic [16:0] w17;
  logic [6:0]  dec_op;
  logic [3:0]  dec_m0, dec_m1, dec_m2;
  always_comb begin
    logic [16:0] h, t;
    w17    = mrdata[16:0];
    h      = 17'((36'(w17) * 36'd167773) >> 24);        // w / 100
    dec_op = 7'(w17 - 17'(h * 17'd100));
    t      = 17'((34'(h) * 34'd6554) >> 16);             // h / 10
    dec_m0 = 4'(h - 17'(t * 17'd10));
    dec_m2 = 4'((34'(t) * 34'd6554) >> 16);              // t / 10
    dec_m1 = 4'(t - 17'(17'(dec_m2) * 17'd10));
  end

  // operand mode for the current index
  logic [3:0] cur_md;
  always_comb begin
    unique case (oi_q)
      2'd0:    cur_md = md0_q;
      2'd1:    cur_md = md1_q;
      default: cur_md = md2_q;
    endcase
  end

  logic [63:0] cur_arg;
  assign cur_arg = a_q[oi_q];
  logic arg_oor;
  assign arg_oor = (cur_arg >= 64'(swmi_pkg::MemWords));

  // 32 x 32 partial product for the multiply, low half of the 64-bit result
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, mul_term;
  always_comb begin
    unique case (mc_q)
      2'd0: begin
        mul_a = x_q[31:0];
        mul_b = y_q[31:0];
      end
      2'd1: begin
        mul_a = x_q[31:0];
        mul_b = y_q[63:32];
      end
      default: begin
        mul_a = x_q[63:32];
        mul_b = y_q[31:0];
      end
    endcase
    mul_p    = 64'(mul_a) * 64'(mul_b);
    mul_term = (mc_q == 2'd0) ? mul_p : {mul_p[31:0], 32'd0};
  end

  // result of the compute step
  logic [63:0] alu_r;
  always_comb begin
    unique case (op_q)
      swmi_pkg::OpAdd: alu_r = x_q + y_q;
      swmi_pkg::OpMul: alu_r = prod_q;
      swmi_pkg::OpLt:  alu_r = {63'd0, ($signed(x_q) < $signed(y_q))};
      default:         alu_r = {63'd0, (x_q == y_q)};
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    steps_d = steps_q;
    outs_d  = outs_q;
    pc_d    = pc_q;
    op_d    = op_q;
    md0_d   = md0_q;
    md1_d   = md1_q;
    md2_d   = md2_q;
    nargs_d = nargs_q;
    ai_d    = ai_q;
    a_d     = a_q;
    x_d     = x_q;
    y_d     = y_q;
    oi_d    = oi_q;
    wait_d  = 1'b0;
    st_d    = st_q;
    mc_d    = mc_q;
    prod_d  = prod_q;
    q_pop   = 1'b0;
    mreq    = '{we: 1'b0, addr: pc_q[swmi_pkg::MemAw-1:0], wdata: '0};
    rv_d    = 1'b0;
    res_d   = '0;

    unique case (state_q)
      StIdle: begin
        mreq.addr = item_i.address[swmi_pkg::MemAw-1:0];
        if (item_acc) begin
          unique case (item_i.mode)
            swmi_pkg::ModeLoad: begin
              mreq.we    = 1'b1;
              mreq.wdata = item_i.value;
            end
            swmi_pkg::ModeRead: state_d = StRdOut;
            swmi_pkg::ModeRun: begin
              pc_d    = '0;
              steps_d = '0;
              outs_d  = '0;
              state_d = StChk;
            end
            default: ;
          endcase
        end
      end
      // accumulate one partial product per cycle
      StMul: begin
        prod_d = prod_q + mul_term;
        mc_d   = mc_q + 1'b1;
        if (mc_q == 2'd2) begin
          state_d = StExec;
        end
      end
      StRdOut: begin
        rv_d    = 1'b1;
        res_d   = '{kind: swmi_pkg::KindRead, out_value: mrdata, status: swmi_pkg::StOk,
                    last: 1'b1};
        state_d = StIdle;
      end
      // check step budget and fetch the instruction word
      StChk: begin
        if (steps_q >= step_limit_q) begin
          st_d = swmi_pkg::StSteps; state_d = StEnd;
        end else if (pc_q >= (swmi_pkg::MemAw+1)'(swmi_pkg::MemWords)) begin
          steps_d = steps_q + 1'b1;
          st_d = swmi_pkg::StAddr; state_d = StEnd;
        end else begin
          steps_d = steps_q + 1'b1;
          pc_d    = pc_q + 1'b1;
          state_d = StDec;
        end
      end
      StDec: begin
        if (mrdata > 64'd99999) begin
          st_d = swmi_pkg::StBadMode; state_d = StEnd;
        end else begin
          op_d  = dec_op;
          md0_d = dec_m0;
          md1_d = dec_m1;
          md2_d = dec_m2;
          ai_d  = '0;
          oi_d  = '0;
          unique case (dec_op)
            swmi_pkg::OpHalt: begin st_d = swmi_pkg::StOk; state_d = StEnd; end
            swmi_pkg::OpAdd, swmi_pkg::OpMul, swmi_pkg::OpLt, swmi_pkg::OpEq: begin
              nargs_d = 2'd3; state_d = StFetch;
            end
            swmi_pkg::OpIn, swmi_pkg::OpOut: begin nargs_d = 2'd1; state_d = StFetch; end
            swmi_pkg::OpJt, swmi_pkg::OpJf: begin nargs_d = 2'd2; state_d = StFetch; end
            default: state_d = StChk;
          endcase
        end
      end
      // issue argument fetch
      StFetch: begin
        if (ai_q == nargs_q) begin
          state_d = StOpnd;
        end else if (pc_q >= (swmi_pkg::MemAw+1)'(swmi_pkg::MemWords)) begin
          st_d = swmi_pkg::StAddr; state_d = StEnd;
        end else begin
          pc_d    = pc_q + 1'b1;
          state_d = StArg;
        end
      end
      StArg: begin
        a_d[ai_q] = mrdata;
        ai_d      = ai_q + 1'b1;
        state_d   = StFetch;
      end
      // resolve operands one by one, then act
      StOpnd: begin
        mreq.addr = cur_arg[swmi_pkg::MemAw-1:0];
        if (wait_q) begin
          if (oi_q == 2'd0) x_d = mrdata; else y_d = mrdata;
          oi_d = oi_q + 1'b1;
        end else if (op_q == swmi_pkg::OpIn ||
                     (op_q == swmi_pkg::OpJt && oi_q == 2'd1 && x_q == 64'd0) ||
                     (op_q == swmi_pkg::OpJf && oi_q == 2'd1 && x_q != 64'd0) ||
                     (oi_q == nargs_q - 2'd1 && op_q != swmi_pkg::OpOut &&
                      op_q != swmi_pkg::OpJt && op_q != swmi_pkg::OpJf) ||
                     oi_q == nargs_q) begin
          mc_d    = '0;
          prod_d  = '0;
          state_d = (op_q == swmi_pkg::OpMul) ? StMul : StExec;
        end else if (cur_md == 4'd1) begin
          if (oi_q == 2'd0) x_d = cur_arg; else y_d = cur_arg;
          oi_d = oi_q + 1'b1;
        end else if (cur_md != 4'd0) begin
          st_d = swmi_pkg::StBadMode; state_d = StEnd;
        end else if (arg_oor) begin
          st_d = swmi_pkg::StAddr; state_d = StEnd;
        end else begin
          wait_d = 1'b1;
        end
      end
      StExec: begin
        state_d = StChk;
        unique case (op_q)
          swmi_pkg::OpOut: begin
            if (outs_q >= swmi_pkg::OutCw'(swmi_pkg::MaxOutputs)) begin
              st_d = swmi_pkg::StOutCap; state_d = StEnd;
            end else begin
              outs_d = outs_q + 1'b1;
              rv_d   = 1'b1;
              res_d  = '{kind: swmi_pkg::KindOut, out_value: x_q,
                         status: swmi_pkg::StOk, last: 1'b0};
            end
          end
          swmi_pkg::OpJt, swmi_pkg::OpJf: begin
            if (oi_q == 2'd2) begin
              pc_d = (y_q >= 64'(swmi_pkg::MemWords)) ?
                     (swmi_pkg::MemAw+1)'(swmi_pkg::MemWords) :
                     y_q[swmi_pkg::MemAw:0];
            end
          end
          default: begin
            // write destination (input or compute)
            if (op_q == swmi_pkg::OpIn && q_empty) begin
              st_d = swmi_pkg::StEmpty; state_d = StEnd;
            end else begin
              q_pop = (op_q == swmi_pkg::OpIn);
              mreq.addr  = cur_arg[swmi_pkg::MemAw-1:0];
              mreq.wdata = (op_q == swmi_pkg::OpIn) ? q_head : alu_r;
              if (cur_md == 4'd1) begin
                st_d = swmi_pkg::StImmWr; state_d = StEnd;
              end else if (cur_md != 4'd0) begin
                st_d = swmi_pkg::StBadMode; state_d = StEnd;
              end else if (arg_oor) begin
                st_d = swmi_pkg::StAddr; state_d = StEnd;
              end else begin
                mreq.we = 1'b1;
              end
            end
          end
        endcase
      end
      StEnd: begin
        rv_d    = 1'b1;
        res_d   = '{kind: swmi_pkg::KindStatus, out_value: '0, status: st_q, last: 1'b1};
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      step_limit_q   <= swmi_pkg::StepLimitReset;
      steps_q        <= '0;
      outs_q         <= '0;
      pc_q           <= '0;
      wait_q         <= 1'b0;
      mc_q           <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      steps_q        <= steps_d;
      outs_q         <= outs_d;
      pc_q           <= pc_d;
      wait_q         <= wait_d;
      mc_q           <= mc_d;
      result_valid_o <= rv_d;
      if (cfg_we_i) begin
        step_limit_q <= cfg_wdata_i;
      end
    end
  end

  // hold decode and operand payload
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    md0_q   <= md0_d;
    md1_q   <= md1_d;
    md2_q   <= md2_d;
    nargs_q <= nargs_d;
    ai_q    <= ai_d;
    a_q     <= a_d;
    x_q     <= x_d;
    y_q     <= y_d;
    oi_q    <= oi_d;
    st_q    <= st_d;
    prod_q  <= prod_d;
    result_o <= res_d;
  end

  // a status result always closes the word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.kind == swmi_pkg::KindStatus |-> result_o.last)
    else $error("status without last");

  // the block is idle when its last result shows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |-> !busy)
    else $error("busy after last result");

  // output count never passes the cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    outs_q <= swmi_pkg::OutCw'(swmi_pkg::MaxOutputs))
    else $error("output cap exceeded");

  // a run starts with a fetch check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc && item_i.mode == swmi_pkg::ModeRun |=> state_q == StChk)
    else $error("run did not start");

endmodule
`default_nettype wire

// File: bench/small_word_machine_interpreter_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module small_word_machine_interpreter_tb;
  import swmi_pkg::*;

  localparam int IdleLimit = 100000;
  localparam int Cont      = 7;
  localparam int PosMode   = 0;
  localparam int ImmMode   = 1;
  localparam int ProgWords = 40;
  localparam int DataTop   = 127;

  // word machine predictor plus the list of results still owed by the block
  class swmi_scoreboard;
    logic [63:0] mem [MemWords];
    bit          written [MemWords];
    logic [63:0] fifo [QueueDepth];
    int unsigned head, count;
    logic [31:0] limit;
    logic [63:0] pc;
    logic [31:0] steps;
    int unsigned outs;
    result_t     owed [$];
    int          errors, runs, results;
    bit          probing;
    int          first_unwritten;

    function new();
      limit = StepLimitReset;
      head = 0;
      count = 0;
      errors = 0;
      runs = 0;
      results = 0;
      probing = 0;
    endfunction

    function void emit(logic [1:0] kind, logic [63:0] val, logic [2:0] st);
      result_t r;
      r.kind = kind;
      r.out_value = val;
      r.status = st;
      r.last = (kind != KindOut);
      owed = {owed, r};
    endfunction

    // read memory, noting the first never-written word a probe touches
    function logic [63:0] peek(logic [63:0] a);
      if (!written[a] && first_unwritten < 0) first_unwritten = int'(a);
      return mem[a];
    endfunction

    function int fetch(output logic [63:0] w);
      w = 0;
      if (pc >= MemWords) return StAddr;
      w = peek(pc);
      pc++;
      return Cont;
    endfunction

    function int get_opnd(int md, logic [63:0] arg, output logic [63:0] v);
      v = 0;
      if (md == ImmMode) begin
        v = arg;
        return Cont;
      end
      if (md != PosMode) return StBadMode;
      if (arg >= MemWords) return StAddr;
      v = peek(arg);
      return Cont;
    endfunction

    function int put_opnd(int md, logic [63:0] arg, logic [63:0] v);
      if (md == ImmMode) return StImmWr;
      if (md != PosMode) return StBadMode;
      if (arg >= MemWords) return StAddr;
      mem[arg] = v;
      written[arg] = 1;
      return Cont;
    endfunction

    function int exec_one();
      logic [63:0] w, x, y, r;
      logic [63:0] a [3];
      int md [3];
      int op, nargs, e;
      x = 0;
      y = 0;
      r = 0;
      a = '{default: 0};
      if (steps >= limit) return StSteps;
      steps++;
      e = fetch(w);
      if (e != Cont) return e;
      if (w > 64'd99999) return StBadMode;
      op = int'(w % 100);
      md[0] = int'((w / 100) % 10);
      md[1] = int'((w / 1000) % 10);
      md[2] = int'(w / 10000);
      case (op)
        OpHalt: return StOk;
        OpAdd, OpMul, OpLt, OpEq: nargs = 3;
        OpIn, OpOut: nargs = 1;
        OpJt, OpJf: nargs = 2;
        default: return Cont;
      endcase
      for (int i = 0; i < nargs; i++) begin
        e = fetch(a[i]);
        if (e != Cont) return e;
      end
      case (op)
        OpIn: begin
          if (count == 0) return StEmpty;
          r = fifo[head % QueueDepth];
          head = (head + 1) % QueueDepth;
          count--;
          return put_opnd(md[0], a[0], r);
        end
        OpOut: begin
          e = get_opnd(md[0], a[0], x);
          if (e != Cont) return e;
          if (outs >= MaxOutputs) return StOutCap;
          outs++;
          emit(KindOut, x, StOk);
          return Cont;
        end
        OpJt, OpJf: begin
          e = get_opnd(md[0], a[0], x);
          if (e != Cont) return e;
          if ((op == OpJt) == (x != 0)) begin
            e = get_opnd(md[1], a[1], y);
            if (e != Cont) return e;
            pc = y;
          end
          return Cont;
        end
        default: begin
          e = get_opnd(md[0], a[0], x);
          if (e != Cont) return e;
          e = get_opnd(md[1], a[1], y);
          if (e != Cont) return e;
          if (op == OpAdd) r = x + y;
          else if (op == OpMul) r = x * y;
          else if (op == OpLt) r = ($signed(x) < $signed(y)) ? 1 : 0;
          else r = (x == y) ? 1 : 0;
          return put_opnd(md[2], a[2], r);
        end
      endcase
    endfunction

    function void run();
      int e;
      pc = 0;
      steps = 0;
      outs = 0;
      do e = exec_one(); while (e == Cont);
      emit(KindStatus, 0, e[2:0]);
    endfunction

    // dry run: first unwritten address the next run would touch, or -1
    function int probe_run();
      logic [63:0] mem_s [MemWords];
      bit wr_s [MemWords];
      logic [63:0] fifo_s [QueueDepth];
      int unsigned head_s, count_s, n_s;
      mem_s = mem;
      wr_s = written;
      fifo_s = fifo;
      head_s = head;
      count_s = count;
      n_s = owed.size();
      first_unwritten = -1;
      probing = 1;
      run();
      probing = 0;
      mem = mem_s;
      written = wr_s;
      fifo = fifo_s;
      head = head_s;
      count = count_s;
      while (owed.size() > n_s) void'(owed.pop_back());
      return first_unwritten;
    endfunction

    // note one accepted input word
    function void note(item_t it);
      case (it.mode)
        ModeLoad: begin
          mem[it.address] = it.value;
          written[it.address] = 1;
        end
        ModePush: begin
          if (count < QueueDepth) begin
            fifo[(head + count) % QueueDepth] = it.value;
            count++;
          end
        end
        ModeRead: emit(KindRead, mem[it.address], StOk);
        default: begin
          runs++;
          run();
        end
      endcase
    endfunction

    // compare one result word with the oldest one owed
    function void check(result_t got);
      result_t want;
      results++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result kind=%0d value=%0d status=%0d last=%0d",
                 $time, got.kind, got.out_value, got.status, got.last);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.out_value !== want.out_value) begin
        $display("%0t: out_value expected %0d actual %0d", $time, want.out_value,
                 got.out_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni, start, busy;
  item_t       item_i;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        result_valid_o;
  result_t     result_o;

  swmi_scoreboard sb = new();
  int  n_items = 0;
  int  n_cfg = 0;
  int  idle_cycles = 0;
  bit  no_idle = 0;
  logic [63:0] prog [$];

  small_word_machine_interpreter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // check every result word as it shows
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check(result_o);
  end

  // stop a run that makes no progress
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // drive one word and hold it until the block takes it
  task automatic send(logic [1:0] m, logic [9:0] ad, logic [63:0] v);
    item_t it;
    int gap;
    it.mode = m;
    it.address = ad;
    it.value = v;
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note(it);
    n_items++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait until every owed result has come and the block has settled
  task automatic drain();
    start <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [31:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.limit = v;
    n_cfg++;
  endtask

  // plug never-written words the run would reach with halts, then run
  task automatic run_prog();
    int b;
    b = sb.probe_run();
    while (b >= 0) begin
      send(ModeLoad, b[9:0], 64'(OpHalt));
      b = sb.probe_run();
    end
    send(ModeRun, 10'($urandom), {$urandom, $urandom});
  endtask

  task automatic load_prog_and_run();
    foreach (prog[i]) send(ModeLoad, 10'(i), prog[i]);
    run_prog();
  endtask

  // one random parameter; kind 0 read, 1 write, 2 jump target
  function automatic void add_param(int kind, output int md);
    logic [63:0] arg;
    if ($urandom_range(0, 19) == 0) md = $urandom_range(2, 9);
    else if (kind == 1 && $urandom_range(0, 7) != 0) md = PosMode;
    else md = $urandom_range(0, 1);
    if (md == ImmMode) begin
      if (kind == 2) arg = $urandom_range(0, ProgWords - 1);
      else if ($urandom_range(0, 3) == 0) arg = {$urandom, $urandom};
      else arg = longint'(int'($urandom_range(0, 100)) - 50);
    end else if ($urandom_range(0, 29) == 0) begin
      if ($urandom_range(0, 1)) arg = 1024 + $urandom_range(0, 5000);
      else arg = -longint'($urandom_range(1, 9));
    end else begin
      arg = $urandom_range(ProgWords, DataTop);
    end
    prog = {prog, arg};
  endfunction

  // build a random program at the bottom of memory
  task automatic gen_prog();
    int op, n, sel, wi;
    int md [3];
    logic [63:0] w;
    prog.delete();
    n = $urandom_range(2, 8);
    for (int k = 0; k < n && prog.size() < ProgWords - 5; k++) begin
      sel = $urandom_range(0, 19);
      case (sel)
        0, 1: op = OpAdd;
        2, 3: op = OpMul;
        4, 5: op = OpIn;
        6, 7, 8: op = OpOut;
        9, 10: op = OpJt;
        11, 12: op = OpJf;
        13, 14: op = OpLt;
        15, 16: op = OpEq;
        17: op = OpHalt;
        default: op = $urandom_range(9, 98);
      endcase
      wi = prog.size();
      prog = {prog, 64'd0};
      md = '{0, 0, 0};
      case (op)
        OpAdd, OpMul, OpLt, OpEq: begin
          add_param(0, md[0]);
          add_param(0, md[1]);
          add_param(1, md[2]);
        end
        OpIn: add_param(1, md[0]);
        OpOut: add_param(0, md[0]);
        OpJt, OpJf: begin
          add_param(0, md[0]);
          add_param(2, md[1]);
        end
        default: ;
      endcase
      w = op + 100 * md[0] + 1000 * md[1] + 10000 * md[2];
      if ($urandom_range(0, 24) == 0) w = $urandom_range(0, 1) ? {$urandom, $urandom}
                                                                : 64'd100000 + $urandom;
      prog[wi] = w;
    end
    prog = {prog, 64'(OpHalt)};
  endtask

  function automatic logic [9:0] pick_read_addr();
    logic [9:0] a;
    for (int t = 0; t < 20; t++) begin
      a = 10'($urandom);
      if (sb.written[a]) return a;
    end
    return 10'd0;
  endfunction

  initial begin
    int target;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes through memory
    send(ModeLoad, 10'd0, 64'h8000_0000_0000_0000);
    send(ModeLoad, 10'd1023, 64'h7fff_ffff_ffff_ffff);
    send(ModeLoad, 10'd682, '1);
    send(ModeRead, 10'd0, 0);
    send(ModeRead, 10'd1023, 0);
    send(ModeRead, 10'd682, 0);

    // fill the input queue past full, then drain it until empty
    for (int i = 0; i < 17; i++) send(ModePush, 0, {$urandom, $urandom});
    prog = '{64'd3, 64'd50, 64'd1105, 64'd1, 64'd0};
    load_prog_and_run();

    // add, multiply, output in both modes
    prog = '{64'd1101, 64'd5, -64'sd7, 64'd60, 64'd2, 64'd60, 64'd60, 64'd61,
             64'd4, 64'd61, 64'd104, -64'sd3, 64'd99};
    load_prog_and_run();

    // input, equals, less-than, jump-if-false
    send(ModePush, 0, 64'd5);
    prog = '{64'd3, 64'd60, 64'd1008, 64'd60, 64'd5, 64'd61, 64'd4, 64'd61,
             64'd1107, -64'sd1, 64'd1, 64'd62, 64'd4, 64'd62, 64'd1106, 64'd0,
             64'd18, 64'd42, 64'd99};
    load_prog_and_run();

    // bad words, bad used mode digit, ignored unused digit
    prog = '{64'd100000};
    load_prog_and_run();
    prog = '{-64'sd1};
    load_prog_and_run();
    prog = '{64'd201, 64'd0, 64'd0, 64'd0};
    load_prog_and_run();
    prog = '{64'd90004, 64'd0, 64'd99};
    load_prog_and_run();

    // immediate write, out-of-range accesses, jump off the end
    prog = '{64'd11101, 64'd1, 64'd1, 64'd5};
    load_prog_and_run();
    prog = '{64'd4, 64'd1024};
    load_prog_and_run();
    prog = '{64'd4, -64'sd5};
    load_prog_and_run();
    prog = '{64'd1105, 64'd1, 64'd2000};
    load_prog_and_run();
    send(ModeLoad, 10'd1022, 64'd42);
    send(ModeLoad, 10'd1023, 64'd42);
    prog = '{64'd1105, 64'd1, 64'd1022};
    load_prog_and_run();

    // step limit near its low end and at its top, output cap under a wider limit, wrapping arithmetic
    set_limit(32'd1);
    prog = '{64'd1101, 64'd1, 64'd1, 64'd60, 64'd99};
    load_prog_and_run();
    set_limit(32'd200);
    prog = '{64'd104, 64'd7, 64'd1105, 64'd1, 64'd0};
    load_prog_and_run();
    set_limit(32'hffff_ffff);
    prog = '{64'd1102, 64'h7fff_ffff_ffff_ffff, 64'd3, 64'd60, 64'd4, 64'd60,
             64'd1101, 64'h7fff_ffff_ffff_ffff, 64'd1, 64'd61, 64'd4, 64'd61, 64'd99};
    load_prog_and_run();

    // random phases, each under its own step limit, up to about 160 words in all
    target = 160;
    while (n_items < target) begin
      case ($urandom_range(0, 4))
        0: set_limit(32'd2);
        1: set_limit(32'd3);
        2: set_limit(32'd17);
        3: set_limit(32'd200);
        default: set_limit(32'd500);
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 30 && n_items < target; k++) begin
        case ($urandom_range(0, 9))
          0: send(ModeLoad, 10'($urandom), {$urandom, $urandom});
          1, 2: send(ModePush, 10'($urandom), $urandom_range(0, 1) ?
                     {$urandom, $urandom} : 64'($urandom_range(0, 127)));
          3, 4: send(ModeRead, pick_read_addr(), {$urandom, $urandom});
          5, 6: begin
            gen_prog();
            load_prog_and_run();
          end
          default: begin
            send(ModeLoad, 10'($urandom_range(0, ProgWords - 1)),
                 64'($urandom_range(0, 11108)));
            run_prog();
          end
        endcase
        // hold off until the block has caught up
        if ($urandom_range(0, 14) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d input words (%0d runs) and %0d result words,",
             n_items, sb.runs, sb.results);
    $display("with %0d step limit settings and %0d mismatches.", n_cfg, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
src/swmi_pkg.sv
src/swmi_mem.sv
src/swmi_queue.sv
src/small_word_machine_interpreter.sv
bench/small_word_machine_interpreter_tb.sv
